>>> sv/tsnt_pkg.sv
`default_nettype none

package tsnt_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 16;

    localparam int CMD_W    = 2;
    localparam int SCORE_W  = 32;
    localparam int STAMP_W  = 32;
    localparam int TAG_W    = 16;
    localparam int INDEX_W  = 4;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_PROBE  = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_BELOW = 2'd1,
        ST_DUP   = 2'd2,
        ST_READ  = 2'd3
    } t_status;

    // One table slot as it is held in the table memory.
    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [STAMP_W-1:0] stamp;
        logic               imported;
        logic [TAG_W-1:0]   tag;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

>>> sv/tsnt_req_if.sv
`default_nettype none

interface tsnt_req_if;
    logic                          valid;
    logic                          ready;
    logic [tsnt_pkg::CMD_W-1:0]    cmd;
    logic [tsnt_pkg::SCORE_W-1:0]  score;
    logic [tsnt_pkg::STAMP_W-1:0]  time_stamp;
    logic                          imported;
    logic [tsnt_pkg::TAG_W-1:0]    name_tag;
    logic [tsnt_pkg::INDEX_W-1:0]  entry_index;

    modport source (
        output valid, cmd, score, time_stamp, imported, name_tag, entry_index,
        input  ready
    );
    modport sink (
        input  valid, cmd, score, time_stamp, imported, name_tag, entry_index,
        output ready
    );
endinterface

interface tsnt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [tsnt_pkg::STATUS_W-1:0] status;
    logic [tsnt_pkg::POS_W-1:0]    position;
    logic [tsnt_pkg::SCORE_W-1:0]  entry_score;
    logic [tsnt_pkg::STAMP_W-1:0]  entry_stamp;
    logic                          entry_imported;
    logic [tsnt_pkg::TAG_W-1:0]    entry_tag;

    modport source (
        output valid, status, position, entry_score, entry_stamp, entry_imported, entry_tag,
        input  ready
    );
    modport sink (
        input  valid, status, position, entry_score, entry_stamp, entry_imported, entry_tag,
        output ready
    );
endinterface

`default_nettype wire

>>> sv/top_n_sorted_table.sv
`default_nettype none

// Sorted top-N table. Holds TABLE_DEPTH entries in descending order of score;
// a slot whose score is zero counts as empty.
// Requests arrive on i_req (valid/ready) with a command: insert, probe rank,
// clear table or read entry. Every request produces exactly one response on
// o_rsp (valid/ready) with a status, a position and, for a read, the slot.
// Insert and probe walk the table from the top, one slot per clock, through
// the single read port of the table memory; an insert writes the new entry
// at its rank and keeps walking to push each lower entry down by one slot.
// A placed insert, an insert that falls below the table and an unmatched
// probe walk the whole table; the walk stops early on a duplicate or a probe
// hit, and a read or a clear does not walk the table at all.
// The slot walk sets the rate: one request is in work at a time, so a new
// request is taken only once the previous response has been registered.
// The response sits in an output register, so the next request is accepted
// while it waits; if the receiver stalls, the following response is held
// inside the block and i_req.ready stays low until the output register frees up.
// Reset (synchronous, active low) clears the per-slot valid bits, which makes
// every slot read as an empty, all-zero entry. No memory sweep is needed.
module top_n_sorted_table #(
    parameter int TABLE_DEPTH = tsnt_pkg::DEFAULT_TABLE_DEPTH
) (
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    tsnt_req_if.sink   i_req,
    tsnt_rsp_if.source o_rsp
);

    import tsnt_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [IDX_W:0] DEPTH_CODE = (IDX_W + 1)'(TABLE_DEPTH);
    localparam logic [POS_W-1:0] POS_NONE = POS_W'(DEPTH_CODE);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WALK = 4'b0010,
        S_READ = 4'b0100,
        S_RESP = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Request held for the duration of the walk.
    t_cmd               r_cmd, n_cmd;
    t_entry             r_new, n_new;

    // Walk control: r_idx is the slot whose data is on the memory output.
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               r_shift, n_shift;
    t_entry             r_carry, n_carry;

    // Slot valid bits; an invalid slot reads as an all-zero entry.
    logic [TABLE_DEPTH-1:0] r_slot_vld, n_slot_vld;

    // Response staged until the output register is free.
    t_status            r_res_status, n_res_status;
    logic [POS_W-1:0]   r_res_pos, n_res_pos;
    t_entry             r_res_entry, n_res_entry;

    // Output register.
    logic               r_out_vld, n_out_vld;
    t_status            r_out_status, n_out_status;
    logic [POS_W-1:0]   r_out_pos, n_out_pos;
    t_entry             r_out_entry, n_out_entry;

    // Table memory port.
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    t_entry             ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    t_entry             slot;
    logic               req_acc;
    logic               out_free;
    logic               idx_last;
    logic [IDX_W+INDEX_W-1:0] read_idx_ext;

    tsnt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;
    assign out_free    = !r_out_vld || o_rsp.ready;

    // Masking by the valid bit gives the all-zero contents of an empty slot.
    assign slot         = r_slot_vld[r_idx] ? t_entry'(ram_rdata) : '0;
    assign idx_last     = (r_idx == IDX_LAST);
    assign read_idx_ext = {{IDX_W{1'b0}}, i_req.entry_index};

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_new        = r_new;
        n_idx        = r_idx;
        n_shift      = r_shift;
        n_carry      = r_carry;
        n_slot_vld   = r_slot_vld;
        n_res_status = r_res_status;
        n_res_pos    = r_res_pos;
        n_res_entry  = r_res_entry;

        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = r_carry;
        // While walking, the next slot is fetched as the current one is used.
        ram_raddr = r_idx + 1'b1;

        unique case (r_state)
            S_IDLE: begin
                ram_raddr = '0;
                if (req_acc) begin
                    n_cmd          = t_cmd'(i_req.cmd);
                    n_new.score    = i_req.score;
                    n_new.stamp    = i_req.time_stamp;
                    n_new.imported = i_req.imported;
                    n_new.tag      = i_req.name_tag;
                    n_idx          = '0;
                    n_shift        = 1'b0;
                    n_res_entry    = '0;
                    unique case (t_cmd'(i_req.cmd))
                        CMD_INSERT, CMD_PROBE: begin
                            n_state = S_WALK;
                        end
                        CMD_CLEAR: begin
                            n_slot_vld   = '0;
                            n_res_status = ST_DONE;
                            n_res_pos    = '0;
                            n_state      = S_RESP;
                        end
                        CMD_READ: begin
                            if (int'(i_req.entry_index) < TABLE_DEPTH) begin
                                ram_raddr = read_idx_ext[IDX_W-1:0];
                                n_idx     = read_idx_ext[IDX_W-1:0];
                                n_state   = S_READ;
                            end else begin
                                n_res_status = ST_BELOW;
                                n_res_pos    = POS_NONE;
                                n_state      = S_RESP;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end

            S_WALK: begin
                n_idx = r_idx + 1'b1;
                if (r_shift) begin
                    // Push the entry displaced from the slot above into this one.
                    ram_we                = 1'b1;
                    ram_wdata             = r_carry;
                    n_slot_vld[r_idx]     = 1'b1;
                    n_carry               = slot;
                    if (idx_last) begin
                        n_state = S_RESP;
                    end
                end else if (r_cmd == CMD_INSERT) begin
                    if (r_new.score == slot.score && r_new.stamp == slot.stamp) begin
                        n_res_status = ST_DUP;
                        n_res_pos    = POS_NONE;
                        n_state      = S_RESP;
                    end else if (r_new.score > slot.score) begin
                        ram_we            = 1'b1;
                        ram_wdata         = r_new;
                        n_slot_vld[r_idx] = 1'b1;
                        n_carry           = slot;
                        n_shift           = 1'b1;
                        n_res_status      = ST_DONE;
                        n_res_pos         = POS_W'(r_idx);
                        if (idx_last) begin
                            n_state = S_RESP;
                        end
                    end else if (idx_last) begin
                        n_res_status = ST_BELOW;
                        n_res_pos    = POS_NONE;
                        n_state      = S_RESP;
                    end
                end else begin
                    // Probe: stop at the first slot with a lower score.
                    if (r_new.score > slot.score) begin
                        n_res_status = ST_DONE;
                        n_res_pos    = POS_W'(r_idx);
                        n_state      = S_RESP;
                    end else if (idx_last) begin
                        n_res_status = ST_BELOW;
                        n_res_pos    = POS_NONE;
                        n_state      = S_RESP;
                    end
                end
            end

            S_READ: begin
                n_res_status = ST_READ;
                n_res_pos    = POS_W'(r_idx);
                n_res_entry  = slot;
                n_state      = S_RESP;
            end

            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_vld    = r_out_vld;
        n_out_status = r_out_status;
        n_out_pos    = r_out_pos;
        n_out_entry  = r_out_entry;
        if (r_out_vld && o_rsp.ready) begin
            n_out_vld = 1'b0;
        end
        if (r_state == S_RESP && out_free) begin
            n_out_vld    = 1'b1;
            n_out_status = r_res_status;
            n_out_pos    = r_res_pos;
            n_out_entry  = r_res_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_shift    <= 1'b0;
            r_slot_vld <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_shift    <= n_shift;
            r_slot_vld <= n_slot_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_new        <= n_new;
        r_idx        <= n_idx;
        r_carry      <= n_carry;
        r_res_status <= n_res_status;
        r_res_pos    <= n_res_pos;
        r_res_entry  <= n_res_entry;
        r_out_status <= n_out_status;
        r_out_pos    <= n_out_pos;
        r_out_entry  <= n_out_entry;
    end

    assign o_rsp.valid          = r_out_vld;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.position       = r_out_pos;
    assign o_rsp.entry_score    = r_out_entry.score;
    assign o_rsp.entry_stamp    = r_out_entry.stamp;
    assign o_rsp.entry_imported = r_out_entry.imported;
    assign o_rsp.entry_tag      = r_out_entry.tag;

    // A clear request empties every slot by the next cycle.
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_acc && i_req.cmd == CMD_CLEAR) |=> (r_slot_vld == '0))
        else $error("clear request left a slot valid");

    // Filled slots always form a run from the top, since entries only shift down.
    a_vld_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_slot_vld & (r_slot_vld + 1'b1)) == '0))
        else $error("slot valid bits are not contiguous from the top");

    // The table memory is written only during a slot walk.
    a_write_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_WALK))
        else $error("table write outside the slot walk");

    // A staged response waits while the output register is still occupied.
    a_resp_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && r_out_vld && !o_rsp.ready) |=> (r_state == S_RESP))
        else $error("staged response dropped while output was stalled");

endmodule

`default_nettype wire

>>> sv/tsnt_ram.sv
`default_nettype none

module tsnt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none

// Testbench for the sorted top-N table.
// A directed table of requests runs first: reads and probes of the empty
// table after reset, zero scores, the extreme scores and stamps, a duplicate,
// an insert that falls below the table, probes, reads and a clear. Rows whose
// response is plain to see carry it typed in. Every other row, and every
// random request that follows, is checked against a predictor that holds its
// own copy of the table. The random part fills the table past its depth, so
// lower entries get pushed out. It also repeats stored scores and stamps, so
// that ties and duplicates come up often.
module tb_top;
    import tsnt_pkg::*;

    localparam int TABLE_DEPTH  = DEFAULT_TABLE_DEPTH;
    localparam int RANDOM_ITEMS = 650;
    localparam int SETTLE_WAIT  = TABLE_DEPTH + 8;
    localparam logic [POS_W-1:0] NO_RANK = POS_W'(TABLE_DEPTH);

    // One request as the table sees it.
    typedef struct {
        t_cmd               cmd;
        logic [SCORE_W-1:0] score;
        logic [STAMP_W-1:0] stamp;
        logic               imported;
        logic [TAG_W-1:0]   tag;
        logic [INDEX_W-1:0] index;
    } t_table_req;

    // One response, field for field as it leaves the block.
    typedef struct {
        t_status            status;
        logic [POS_W-1:0]   position;
        logic [SCORE_W-1:0] entry_score;
        logic [STAMP_W-1:0] entry_stamp;
        logic               entry_imported;
        logic [TAG_W-1:0]   entry_tag;
    } t_table_rsp;

    // A row of the directed table. When typed is set, rsp holds the response
    // written out by hand; otherwise the predictor supplies it.
    typedef struct {
        t_table_req req;
        bit         typed;
        t_table_rsp rsp;
    } t_directed_row;

    logic i_clk;
    logic i_rst_n;

    tsnt_req_if req_if ();
    tsnt_rsp_if rsp_if ();

    top_n_sorted_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_rsp  (rsp_if.source)
    );

    // The predictor's own copy of the table, slot 0 holding the top score.
    t_entry shadow_table [TABLE_DEPTH];

    // Responses still owed by the block, oldest first.
    t_table_rsp owed_rsp [$];
    t_directed_row directed_rows [$];

    int mismatch_count = 0;
    int burst_left     = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Generous limit. Even with the longest stalls on both sides, the run
    // takes well under a tenth of this.
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t: %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic void clear_shadow_table();
        foreach (shadow_table[i]) shadow_table[i] = '0;
    endfunction

    // Apply one request to the shadow table and return the response that it
    // must produce. An insert walks from the top: a slot with the same score
    // and stamp stops the walk as a duplicate, and the first slot whose score
    // is lower takes the entry, with everything below moving down one slot
    // and the bottom entry falling out.
    function automatic t_table_rsp apply_table_command(input t_table_req r);
        t_table_rsp o;
        bit         hit;
        int         i;
        int         k;
        o.status         = ST_BELOW;
        o.position       = NO_RANK;
        o.entry_score    = '0;
        o.entry_stamp    = '0;
        o.entry_imported = 1'b0;
        o.entry_tag      = '0;
        hit = 1'b0;
        case (r.cmd)
            CMD_INSERT: begin
                for (i = 0; i < TABLE_DEPTH && !hit; i++) begin
                    if (r.score == shadow_table[i].score &&
                        r.stamp == shadow_table[i].stamp) begin
                        o.status = ST_DUP;
                        hit      = 1'b1;
                    end else if (r.score > shadow_table[i].score) begin
                        for (k = TABLE_DEPTH - 1; k > i; k--) begin
                            shadow_table[k] = shadow_table[k-1];
                        end
                        shadow_table[i].score    = r.score;
                        shadow_table[i].stamp    = r.stamp;
                        shadow_table[i].imported = r.imported;
                        shadow_table[i].tag      = r.tag;
                        o.status   = ST_DONE;
                        o.position = POS_W'(i);
                        hit        = 1'b1;
                    end
                end
            end
            CMD_PROBE: begin
                for (i = 0; i < TABLE_DEPTH && !hit; i++) begin
                    if (r.score > shadow_table[i].score) begin
                        o.status   = ST_DONE;
                        o.position = POS_W'(i);
                        hit        = 1'b1;
                    end
                end
            end
            CMD_CLEAR: begin
                clear_shadow_table();
                o.status   = ST_DONE;
                o.position = '0;
            end
            default: begin
                if (int'(r.index) < TABLE_DEPTH) begin
                    o.status         = ST_READ;
                    o.position       = POS_W'(r.index);
                    o.entry_score    = shadow_table[r.index].score;
                    o.entry_stamp    = shadow_table[r.index].stamp;
                    o.entry_imported = shadow_table[r.index].imported;
                    o.entry_tag      = shadow_table[r.index].tag;
                end
            end
        endcase
        return o;
    endfunction

    // Queue a directed row. Typed rows only ever carry zero entry fields.
    task automatic add_row(input t_cmd cmd, input logic [SCORE_W-1:0] score,
                           input logic [STAMP_W-1:0] stamp, input logic imported,
                           input logic [TAG_W-1:0] tag, input logic [INDEX_W-1:0] index,
                           input bit typed, input t_status status,
                           input logic [POS_W-1:0] position);
        t_directed_row row;
        row.req.cmd             = cmd;
        row.req.score           = score;
        row.req.stamp           = stamp;
        row.req.imported        = imported;
        row.req.tag             = tag;
        row.req.index           = index;
        row.typed               = typed;
        row.rsp.status          = status;
        row.rsp.position        = position;
        row.rsp.entry_score     = '0;
        row.rsp.entry_stamp     = '0;
        row.rsp.entry_imported  = 1'b0;
        row.rsp.entry_tag       = '0;
        directed_rows.push_back(row);
    endtask

    // Scores are drawn so that ties with stored entries are common: zero,
    // the extremes, the score of a stored slot, a small value, or anything.
    function automatic logic [SCORE_W-1:0] pick_score();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)       return '0;
        else if (roll < 14) return '1;
        else if (roll < 18) return SCORE_W'(1);
        else if (roll < 32) return shadow_table[$urandom_range(0, TABLE_DEPTH-1)].score;
        else if (roll < 65) return SCORE_W'($urandom_range(1, 20));
        else                return $urandom;
    endfunction

    // Inserts outnumber every other request, so the table fills up and overflows
    // between the rare clears. Some inserts repeat a stored score and stamp on purpose.
    function automatic t_table_req random_request();
        t_table_req r;
        int         roll;
        int         slot;
        roll       = $urandom_range(0, 199);
        r.imported = 1'($urandom_range(0, 1));
        r.tag      = TAG_W'($urandom);
        r.index    = INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1));
        r.score    = pick_score();
        r.stamp    = $urandom_range(0, 1) ? STAMP_W'($urandom_range(0, 3)) : $urandom;
        if (roll < 3)        r.cmd = CMD_CLEAR;
        else if (roll < 100) r.cmd = CMD_INSERT;
        else if (roll < 140) r.cmd = CMD_PROBE;
        else                 r.cmd = CMD_READ;
        if (r.cmd == CMD_INSERT && $urandom_range(0, 6) == 0) begin
            slot    = $urandom_range(0, TABLE_DEPTH - 1);
            r.score = shadow_table[slot].score;
            r.stamp = shadow_table[slot].stamp;
        end
        return r;
    endfunction

    // Present one request and hold it until the block takes it. The
    // expected response is recorded at the accepting edge. Valid stays high
    // across a burst; at the end of a burst the sender goes quiet and then
    // picks the length of the next burst.
    task automatic offer(input t_table_req r, input bit typed, input t_table_rsp typed_rsp);
        t_table_rsp predicted;
        int         gap;
        req_if.valid       <= 1'b1;
        req_if.cmd         <= r.cmd;
        req_if.score       <= r.score;
        req_if.time_stamp  <= r.stamp;
        req_if.imported    <= r.imported;
        req_if.name_tag    <= r.tag;
        req_if.entry_index <= r.index;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        predicted = apply_table_command(r);
        owed_rsp.push_back(typed ? typed_rsp : predicted);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 6);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // Stop sending until every owed response is back.
    task automatic wait_for_table_idle();
        req_if.valid <= 1'b0;
        while (owed_rsp.size() != 0) @(posedge i_clk);
    endtask

    // The receiver stalls in phases of random length: always ready, ready at
    // random with a chance of three in four, or long stretches of stall with
    // short windows of ready. Phases change independently of the sender.
    initial begin : receiver
        int stall_mode;
        int phase_left;
        int phase_cycle;
        stall_mode  = 0;
        phase_left  = 0;
        phase_cycle = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (phase_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                phase_left = $urandom_range(16, 120);
            end
            phase_left--;
            phase_cycle++;
            case (stall_mode)
                0:       rsp_if.ready <= 1'b1;
                1:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
                default: rsp_if.ready <= ((phase_cycle % 7) < 2);
            endcase
        end
    end

    // Response checker. It samples at the rising edge, so it sees the values
    // that were settled before the edge, the same values the block itself
    // acts on.
    always @(posedge i_clk) begin
        t_table_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (owed_rsp.size() == 0) begin
                flag_mismatch("response with no request owed", 32'(rsp_if.status), 32'hx);
            end else begin
                want = owed_rsp.pop_front();
                if (rsp_if.status !== want.status)
                    flag_mismatch("status", 32'(rsp_if.status), 32'(want.status));
                if (rsp_if.position !== want.position)
                    flag_mismatch("position", 32'(rsp_if.position), 32'(want.position));
                if (rsp_if.entry_score !== want.entry_score)
                    flag_mismatch("entry_score", rsp_if.entry_score, want.entry_score);
                if (rsp_if.entry_stamp !== want.entry_stamp)
                    flag_mismatch("entry_stamp", rsp_if.entry_stamp, want.entry_stamp);
                if (rsp_if.entry_imported !== want.entry_imported)
                    flag_mismatch("entry_imported", 32'(rsp_if.entry_imported),
                                  32'(want.entry_imported));
                if (rsp_if.entry_tag !== want.entry_tag)
                    flag_mismatch("entry_tag", 32'(rsp_if.entry_tag), 32'(want.entry_tag));
            end
        end
    end

    initial begin : stimulus
        t_table_req    item;
        t_table_rsp    none;
        t_directed_row row;
        none = '{status: ST_DONE, position: '0, entry_score: '0, entry_stamp: '0,
                 entry_imported: 1'b0, entry_tag: '0};

        // Every input of the block starts at a known value.
        i_rst_n            <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.cmd         <= CMD_INSERT;
        req_if.score       <= '0;
        req_if.time_stamp  <= '0;
        req_if.imported    <= 1'b0;
        req_if.name_tag    <= '0;
        req_if.entry_index <= '0;
        clear_shadow_table();

        // After reset every slot reads back empty, and nothing ranks below
        // the empty table except a score of zero.
        add_row(CMD_READ,   '0, '0, 1'b0, '0, 4'd0,  1, ST_READ,  5'd0);
        add_row(CMD_READ,   '1, '1, 1'b1, '1, 4'd15, 1, ST_READ,  5'd15);
        add_row(CMD_PROBE,  '0, '0, 1'b0, '0, 4'd0,  1, ST_BELOW, NO_RANK);
        add_row(CMD_PROBE,  '1, '0, 1'b0, '0, 4'd0,  1, ST_DONE,  5'd0);
        // A zero score meets the empty top slot: with a zero stamp it counts
        // as a duplicate, with any other stamp it falls below the table.
        add_row(CMD_INSERT, '0, '0, 1'b0, '0, 4'd0,  1, ST_DUP,   NO_RANK);
        add_row(CMD_INSERT, '0, 32'd7, 1'b1, 16'h1111, 4'd0, 1, ST_BELOW, NO_RANK);
        // Top score with every bit set lands on top, and again is a duplicate.
        add_row(CMD_INSERT, '1, '1, 1'b1, '1, 4'd0,  1, ST_DONE,  5'd0);
        add_row(CMD_INSERT, '1, '1, 1'b1, '1, 4'd0,  1, ST_DUP,   NO_RANK);
        // Same score with a new stamp goes below its twin.
        add_row(CMD_INSERT, '1, '0, 1'b0, '0, 4'd9,  0, ST_DONE,  '0);
        add_row(CMD_INSERT, 32'd1, 32'd1, 1'b1, 16'h1234, 4'd0, 0, ST_DONE, '0);
        add_row(CMD_INSERT, 32'h8000_0000, 32'h5555_5555, 1'b0, 16'hAAAA, 4'd0,
                0, ST_DONE, '0);
        add_row(CMD_PROBE,  '1, '0, 1'b0, '0, 4'd0,  0, ST_DONE,  '0);
        add_row(CMD_PROBE,  32'd1, '0, 1'b0, '0, 4'd0, 0, ST_DONE, '0);
        add_row(CMD_PROBE,  32'd2, '0, 1'b0, '0, 4'd0, 0, ST_DONE, '0);
        add_row(CMD_READ,   '0, '0, 1'b0, '0, 4'd0,  0, ST_DONE,  '0);
        add_row(CMD_READ,   '0, '0, 1'b0, '0, 4'd1,  0, ST_DONE,  '0);
        add_row(CMD_READ,   '0, '0, 1'b0, '0, 4'd2,  0, ST_DONE,  '0);
        add_row(CMD_READ,   '0, '0, 1'b0, '0, 4'd3,  0, ST_DONE,  '0);
        // Duplicate found low in the table, after higher slots compared.
        add_row(CMD_INSERT, 32'd1, 32'd1, 1'b0, '0, 4'd0, 0, ST_DONE, '0);
        // Clear empties the table; a read and a zero insert show it.
        add_row(CMD_CLEAR,  '1, '1, 1'b1, '1, 4'd15, 1, ST_DONE,  5'd0);
        add_row(CMD_READ,   '0, '0, 1'b0, '0, 4'd0,  1, ST_READ,  5'd0);
        add_row(CMD_INSERT, '0, '0, 1'b1, '1, 4'd0,  1, ST_DUP,   NO_RANK);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            offer(row.req, row.typed, row.rsp);
        end
        wait_for_table_idle();

        // Random part, with one more full drain halfway through.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            item = random_request();
            offer(item, 1'b0, none);
            if (n == RANDOM_ITEMS / 2) wait_for_table_idle();
        end

        wait_for_table_idle();
        repeat (SETTLE_WAIT) @(posedge i_clk);

        if (mismatch_count == 0 && owed_rsp.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
